/* rtl/fxalu_pkg.sv */
// Shared types, action codes and word constants for the Q24.8 arithmetic unit.
package fxalu_pkg;

  localparam int WordBits   = 32;
  localparam int FracBits   = 8;
  localparam int QuoBits    = WordBits + FracBits;
  localparam int ProdBits   = 2 * WordBits;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_MIN = 4'd4,
    ACT_MAX = 4'd5,
    ACT_INC = 4'd6,
    ACT_DEC = 4'd7,
    ACT_I2F = 4'd8,
    ACT_F2I = 4'd9
  } action_e;

  typedef struct packed {
    logic [3:0]                 action;
    logic signed [WordBits-1:0] operand_a;
    logic signed [WordBits-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [WordBits-1:0] result_value;
    logic                       a_greater;
    logic                       a_less;
    logic                       a_equal;
    logic                       overflow_flag;
    logic                       divide_by_zero;
  } out_item_t;

  // decoded operation as it sits in the queue
  typedef struct packed {
    logic [3:0]                 action;
    logic signed [WordBits-1:0] a;
    logic signed [WordBits-1:0] b;
    logic [WordBits-1:0]        mag_a;
    logic [WordBits-1:0]        mag_b;
    logic                       neg;
    logic                       b_zero;
    logic                       gt;
    logic                       lt;
    logic                       eq;
  } job_t;

  // one slot of the execution pipeline
  typedef struct packed {
    job_t                job;
    logic [WordBits-1:0] rem;
    logic [QuoBits-1:0]  quo;
    logic [QuoBits-1:0]  num;
    logic [ProdBits-1:0] prod;
  } stage_t;

endpackage

/* rtl/fxalu_front.sv */
// Front end: decodes an incoming item into magnitudes, result sign and compare flags.
module fxalu_front import fxalu_pkg::*; (
  input  in_item_t item_i,
  output job_t     job_o
);

  always_comb begin
    job_o.action = item_i.action;
    job_o.a      = item_i.operand_a;
    job_o.b      = item_i.operand_b;
    job_o.mag_a  = item_i.operand_a[WordBits-1] ? (WordBits)'(-item_i.operand_a)
                                                : item_i.operand_a;
    job_o.mag_b  = item_i.operand_b[WordBits-1] ? (WordBits)'(-item_i.operand_b)
                                                : item_i.operand_b;
    job_o.neg    = item_i.operand_a[WordBits-1] ^ item_i.operand_b[WordBits-1];
    job_o.b_zero = (item_i.operand_b == '0);
    job_o.gt     = (item_i.operand_a > item_i.operand_b);
    job_o.lt     = (item_i.operand_a < item_i.operand_b);
    job_o.eq     = (item_i.operand_a == item_i.operand_b);
  end

endmodule

/* rtl/fxalu_queue.sv */
// Small FIFO of decoded jobs between front end and execution pipeline.
module fxalu_queue import fxalu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o    = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QueuePtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == QueuePtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

endmodule

/* rtl/fxalu_back.sv */
// Execution pipeline: multiplier, one-bit-per-stage divider, rounding and saturation.
module fxalu_back import fxalu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  stage_t            st_q [QuoBits+1];
  stage_t            st_d [QuoBits];
  logic [QuoBits:0]  vld_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              adv;

  assign adv         = !out_valid_q || out_ready_i;
  assign job_ready_o = adv;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  function automatic stage_t div_step(stage_t s);
    logic [WordBits:0] trial;
    logic              qbit;
    stage_t            r;
    r     = s;
    trial = {s.rem, s.num[QuoBits-1]};
    qbit  = (trial >= {1'b0, s.job.mag_b});
    r.rem = qbit ? WordBits'(trial - {1'b0, s.job.mag_b}) : trial[WordBits-1:0];
    r.num = s.num << 1;
    r.quo = {s.quo[QuoBits-2:0], qbit};
    return r;
  endfunction

  function automatic out_item_t finish(stage_t s);
    logic signed [WordBits:0] sum;
    logic [ProdBits:0]        pr;
    logic [ProdBits:0]        sh;
    logic [WordBits-1:0]      lim;
    logic                     rnd;
    logic [QuoBits:0]         q2;
    out_item_t                o;
    o.result_value   = '0;
    o.overflow_flag  = 1'b0;
    o.divide_by_zero = 1'b0;
    o.a_greater      = s.job.gt;
    o.a_less         = s.job.lt;
    o.a_equal        = s.job.eq;
    lim = s.job.neg ? WordMin : WordMax;
    sum = '0;
    pr  = '0;
    sh  = '0;
    rnd = 1'b0;
    q2  = '0;
    case (action_e'(s.job.action))
      ACT_ADD, ACT_SUB: begin
        if (action_e'(s.job.action) == ACT_ADD) sum = s.job.a + s.job.b;
        else                                    sum = s.job.a - s.job.b;
        if (sum[WordBits] != sum[WordBits-1]) begin
          o.overflow_flag = 1'b1;
          o.result_value  = sum[WordBits] ? WordMin : WordMax;
        end else begin
          o.result_value = sum[WordBits-1:0];
        end
      end
      ACT_MUL: begin
        pr = {1'b0, s.prod} + (ProdBits+1)'(1 << (FracBits-1));
        sh = pr >> FracBits;
        if (sh > {{(ProdBits+1-WordBits){1'b0}}, lim}) begin
          o.overflow_flag = 1'b1;
          o.result_value  = s.job.neg ? WordMin : WordMax;
        end else begin
          o.result_value = s.job.neg ? WordBits'(-sh[WordBits-1:0]) : sh[WordBits-1:0];
        end
      end
      ACT_DIV: begin
        if (s.job.b_zero) begin
          o.divide_by_zero = 1'b1;
        end else begin
          rnd = ({s.rem, 1'b0} >= {1'b0, s.job.mag_b});
          q2  = {1'b0, s.quo} + (QuoBits+1)'(rnd);
          if (q2 > {{(QuoBits+1-WordBits){1'b0}}, lim}) begin
            o.overflow_flag = 1'b1;
            o.result_value  = s.job.neg ? WordMin : WordMax;
          end else begin
            o.result_value = s.job.neg ? WordBits'(-q2[WordBits-1:0]) : q2[WordBits-1:0];
          end
        end
      end
      ACT_MIN: o.result_value = s.job.gt ? s.job.b : s.job.a;
      ACT_MAX: o.result_value = s.job.gt ? s.job.a : s.job.b;
      ACT_INC: begin
        if (s.job.a == WordMax) begin
          o.overflow_flag = 1'b1;
          o.result_value  = WordMax;
        end else begin
          o.result_value = s.job.a + 1'b1;
        end
      end
      ACT_DEC: begin
        if (s.job.a == WordMin) begin
          o.overflow_flag = 1'b1;
          o.result_value  = WordMin;
        end else begin
          o.result_value = s.job.a - 1'b1;
        end
      end
      ACT_I2F: begin
        if (s.job.a > (WordMax >>> FracBits)) begin
          o.overflow_flag = 1'b1;
          o.result_value  = WordMax;
        end else if (s.job.a < (WordMin >>> FracBits)) begin
          o.overflow_flag = 1'b1;
          o.result_value  = WordMin;
        end else begin
          o.result_value = s.job.a <<< FracBits;
        end
      end
      ACT_F2I: o.result_value = s.job.a >>> FracBits;
      default: o.result_value = '0;
    endcase
    return o;
  endfunction

  for (genvar k = 0; k < QuoBits; k++) begin : g_step
    always_comb begin
      st_d[k] = div_step(st_q[k]);
      if (k == 0) st_d[k].prod = st_q[k].job.mag_a * st_q[k].job.mag_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[QuoBits-1:0], job_valid_i};
      out_valid_q <= vld_q[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].job  <= job_i;
      st_q[0].rem  <= '0;
      st_q[0].quo  <= '0;
      st_q[0].num  <= {job_i.mag_a, {FracBits{1'b0}}};
      st_q[0].prod <= '0;
      for (int k = 0; k < QuoBits; k++) st_q[k+1] <= st_d[k];
      out_q <= finish(st_q[QuoBits]);
    end
  end

endmodule

/* rtl/q24_8_fixed_point_alu_top.sv */
// Top level of the Q24.8 fixed-point arithmetic unit.
// Signed 32-bit fixed-point unit with 8 fraction bits: add, subtract, multiply,
// divide, min, max, increment, decrement, integer-to-fixed and fixed-to-integer,
// with saturation on overflow, divide-by-zero and compare flags on every item.
// Multiply and divide round half away from zero. Throughput is one item per
// cycle while outputs are taken. Every item takes the same path: a two-entry
// queue behind the decoder, then a 42-stage execution pipeline (entry stage,
// 40 divider stages retiring one quotient bit each, with the multiplier in the
// first of them, and the rounding/saturation output register), so results come
// out in order. The quotient width, 32 + 8, sets the divider depth. The whole
// pipeline holds while the output item is not taken.
module q24_8_fixed_point_alu_top import fxalu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  job_t dec_job, q_job;
  logic q_full, q_valid, back_ready;

  fxalu_front u_front (
    .item_i (in_item_i),
    .job_o  (dec_job)
  );

  assign in_ready_o = !q_full;

  fxalu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_job_i (dec_job),
    .full_o     (q_full),
    .pop_i      (back_ready),
    .valid_o    (q_valid),
    .pop_job_o  (q_job)
  );

  fxalu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_ready_o (back_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
